[hdl/sra_pkg.sv]
// Shared constants and types for the sequential readahead window.
package sra_pkg;
  localparam int unsigned DefNumAlign = 4;
  localparam int unsigned MaxGranules = 8;
  localparam logic [15:0] ResetTrigger = 16'd10;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [2:0] CFG_TRIGGER = 3'd0;
  localparam logic [2:0] CFG_MIN = 3'd1;
  localparam logic [2:0] CFG_MAX = 3'd2;
  localparam logic [2:0] CFG_ALIGN0 = 3'd3;
  localparam logic [2:0] CFG_ALIGN3 = 3'd6;

  typedef logic [63:0] word_t;

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? AllOnes : s[63:0];
  endfunction
endpackage

[hdl/sra_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
module sra_div import sra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  word_t    dividend,
  input  word_t    divisor,
  output logic     busy,
  output logic     done,
  output word_t    remainder
);
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  word_t quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [65:0] trial;

  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    trial = {1'b0, rem_r, quo_r[63]} - {2'b00, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 7'd0;
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[62:0], 1'b0};
      if (!trial[65]) rem_nxt = trial[63:0];
      else rem_nxt = {rem_r[62:0], quo_r[63]};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign remainder = rem_r;
endmodule

[hdl/sequential_readahead_window.sv]
// Sequential readahead window top level: sequencer, state and config registers.
// An item with batch_end low is taken while the sequencer stays idle. With
// batch_end high the window is checked; with no readahead due the sequencer
// goes to its output state, else it clamps the window and tries each alignment
// granule in turn (a nonzero one on the shared bit-serial 64-bit divider, a zero
// one skipped) until one snaps or all are tried, then clips. Output stalls add waits.
// The result sits in an output register; the next item is taken once it leaves.
module sequential_readahead_window import sra_pkg::*; #(
  parameter int unsigned NUM_ALIGNMENTS = DefNumAlign
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_read_offset,
  input  logic [63:0] in_read_length,
  input  logic [63:0] in_file_limit,
  input  logic        in_batch_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_ahead_offset,
  output logic [63:0] out_ahead_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int unsigned NG = (NUM_ALIGNMENTS > MaxGranules) ? MaxGranules : NUM_ALIGNMENTS;
  localparam int unsigned GW = (NG > 1) ? $clog2(NG) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WIN = 3'd1;
  localparam logic [2:0] S_CLAMP = 3'd2;
  localparam logic [2:0] S_GRAN = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_SNAP = 3'd5;
  localparam logic [2:0] S_CLIP = 3'd6;
  localparam logic [2:0] S_OUT = 3'd7;

  logic [2:0] st_r, st_nxt;
  logic [15:0] trig_r, run_cnt_r, run_cnt_nxt;
  word_t min_r, max_r;
  word_t align_r [MaxGranules];
  word_t exp_r, exp_nxt, rbytes_r, rbytes_nxt, wpos_r, wpos_nxt;
  word_t tpt_r, tpt_nxt, wsize_r, wsize_nxt;
  word_t limit_r, limit_nxt, len_r, len_nxt, end_r, end_nxt, g_r, g_nxt;
  word_t oo_r, oo_nxt, ol_r, ol_nxt;
  logic [GW-1:0] gi_r, gi_nxt;
  logic ov_r, ov_nxt;
  logic [3:0] gcnt;
  logic div_start, div_busy, div_done;
  word_t rem, prev, next, dprev, dnext, half, gsel;

  sra_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(end_r), .divisor(g_r),
    .busy(div_busy), .done(div_done), .remainder(rem)
  );

  assign in_stall = (st_r != S_IDLE) || ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_ahead_offset = oo_r;
  assign out_ahead_length = ol_r;

  always_comb begin
    gsel = align_r[3'(gi_r)];
    prev = end_r - rem;
    next = sat_add(prev, g_r);
    dprev = end_r - prev;
    dnext = next - end_r;
    half = {1'b0, len_r[63:1]};
    gcnt = 4'(gi_r) + 4'd1;
  end

  always_comb begin
    st_nxt = st_r;
    run_cnt_nxt = run_cnt_r;
    exp_nxt = exp_r;
    rbytes_nxt = rbytes_r;
    wpos_nxt = wpos_r;
    tpt_nxt = tpt_r;
    wsize_nxt = wsize_r;
    limit_nxt = limit_r;
    len_nxt = len_r;
    end_nxt = end_r;
    g_nxt = g_r;
    gi_nxt = gi_r;
    oo_nxt = oo_r;
    ol_nxt = ol_r;
    ov_nxt = ov_r;
    div_start = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          if (in_read_offset == exp_r) begin
            if (run_cnt_r != 16'hFFFF) run_cnt_nxt = run_cnt_r + 16'd1;
            rbytes_nxt = sat_add(rbytes_r, in_read_length);
          end else begin
            run_cnt_nxt = '0;
            rbytes_nxt = '0;
            tpt_nxt = '0;
            wsize_nxt = '0;
            wpos_nxt = '0;
          end
          exp_nxt = sat_add(in_read_offset, in_read_length);
          limit_nxt = in_file_limit;
          if (in_batch_end) st_nxt = S_WIN;
        end
      end
      S_WIN: begin
        oo_nxt = '0;
        ol_nxt = '0;
        if (wpos_r >= limit_r || run_cnt_r < trig_r || exp_r < tpt_r) begin
          st_nxt = S_OUT;
        end else begin
          if (wsize_r == '0) begin
            wsize_nxt = rbytes_r;
            wpos_nxt = exp_r;
          end else begin
            wsize_nxt = wsize_r[63] ? AllOnes : {wsize_r[62:0], 1'b0};
            if (exp_r > wpos_r) wpos_nxt = exp_r;
          end
          st_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        len_nxt = (wsize_r < min_r) ? min_r : wsize_r;
        if (len_nxt > max_r) len_nxt = max_r;
        wsize_nxt = len_nxt;
        end_nxt = sat_add(wpos_r, len_nxt);
        gi_nxt = '0;
        st_nxt = S_GRAN;
      end
      S_GRAN: begin
        if (gsel != '0) begin
          g_nxt = gsel;
          st_nxt = S_DIVW;
        end else if (gcnt == 4'(NG)) begin
          st_nxt = S_CLIP;
        end else begin
          gi_nxt = gi_r + GW'(1);
        end
      end
      S_DIVW: begin
        if (!div_busy && !div_done) div_start = 1'b1;
        if (div_done) st_nxt = S_SNAP;
      end
      S_SNAP: begin
        if (dprev < half && dprev < dnext && prev > wpos_r) begin
          len_nxt = prev - wpos_r;
          st_nxt = S_CLIP;
        end else if (dnext < half && next > wpos_r) begin
          len_nxt = next - wpos_r;
          st_nxt = S_CLIP;
        end else if (gcnt == 4'(NG)) begin
          st_nxt = S_CLIP;
        end else begin
          gi_nxt = gi_r + GW'(1);
          st_nxt = S_GRAN;
        end
      end
      S_CLIP: begin
        if (wpos_r >= limit_r) len_nxt = '0;
        else if (len_r > limit_r - wpos_r) len_nxt = limit_r - wpos_r;
        tpt_nxt = sat_add(wpos_r, {1'b0, len_nxt[63:1]});
        wpos_nxt = sat_add(wpos_r, len_nxt);
        oo_nxt = wpos_r;
        ol_nxt = len_nxt;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      trig_r <= ResetTrigger;
      min_r <= '0;
      max_r <= AllOnes;
      for (int i = 0; i < MaxGranules; i++) align_r[i] <= '0;
      run_cnt_r <= '0;
      exp_r <= '0;
      rbytes_r <= '0;
      wpos_r <= '0;
      tpt_r <= '0;
      wsize_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      run_cnt_r <= run_cnt_nxt;
      exp_r <= exp_nxt;
      rbytes_r <= rbytes_nxt;
      wpos_r <= wpos_nxt;
      tpt_r <= tpt_nxt;
      wsize_r <= wsize_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TRIGGER: trig_r <= cfg_data[15:0];
          CFG_MIN: min_r <= cfg_data;
          CFG_MAX: max_r <= cfg_data;
          default: begin
            if (cfg_index inside {[CFG_ALIGN0:CFG_ALIGN3]})
              align_r[cfg_index - CFG_ALIGN0] <= cfg_data;
          end
        endcase
      end
    end
    limit_r <= limit_nxt;
    len_r <= len_nxt;
    end_r <= end_nxt;
    g_r <= g_nxt;
    gi_r <= gi_nxt;
    oo_r <= oo_nxt;
    ol_r <= ol_nxt;
  end
endmodule
